[rtl/core/ffaa_pkg.sv]
// shared constants, header word type and status codes for the arena allocator
`timescale 1ns / 1ps
`default_nettype none
package ffaa_pkg;
	// arena geometry
	localparam int ARENA_BYTES  = 4096;
	localparam int HEADER_BYTES = 24;
	localparam int AW = $clog2(ARENA_BYTES);
	localparam int SW = $clog2(ARENA_BYTES);
	// working width for offset and size sums
	localparam int XW = (AW + 2 > 18) ? AW + 2 : 18;
	localparam logic [7:0] SLACK_RESET = 8'd20;

	// request codes
	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	// status codes
	localparam logic [2:0] ST_ALLOC      = 3'd0;
	localparam logic [2:0] ST_ALLOC_ZERO = 3'd1;
	localparam logic [2:0] ST_NO_SPACE   = 3'd2;
	localparam logic [2:0] ST_FREED      = 3'd3;
	localparam logic [2:0] ST_NULL_FREE  = 3'd4;
	localparam logic [2:0] ST_BAD_FREE   = 3'd5;

	// in-arena block header
	typedef struct packed {
		logic [SW-1:0] size;
		logic          free;
		logic [AW-1:0] prev;
		logic          has_prev;
	} hdr_t;

	localparam int HDR_W = $bits(hdr_t);
endpackage
`default_nettype wire

[rtl/core/ffaa_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module ffaa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[rtl/core/first_fit_arena_allocator.sv]
// first-fit arena allocator with coalescing, headers kept in block ram
// After reset the block clears its outstanding-offset ram and holds busy high. An allocate
// walks the block headers first-fit (one header ram read per cycle) until one fits or the
// arena ends; on a fit it writes the split-off header and the next block's back link when
// the block is split, then marks the chosen block allocated. A free of an outstanding offset
// merges with free neighbours; other frees are refused, null and out-of-range ones from idle.
// The result appears on status and payload_offset for the single cycle that done is high,
// and the receiver cannot stall it.
// split_slack is written through cfg_valid/cfg_data while busy is low.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_arena_allocator import ffaa_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        mode,
	input  wire logic [15:0] request_size,
	input  wire logic [11:0] free_offset,
	output logic             done,
	output logic [2:0]       status,
	output logic [11:0]      payload_offset,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data
);
	typedef enum logic [9:0] {
		S_CLR  = 10'b0000000001,
		S_IDLE = 10'b0000000010,
		S_ACHK = 10'b0000000100,
		S_AFIX = 10'b0000001000,
		S_AWP  = 10'b0000010000,
		S_FCHK = 10'b0000100000,
		S_FP   = 10'b0001000000,
		S_FN   = 10'b0010000000,
		S_FNN  = 10'b0100000000,
		S_FWK  = 10'b1000000000
	} state_t;

	localparam logic [XW-1:0] ARENA_X = XW'(ARENA_BYTES);
	localparam logic [XW-1:0] HDR_X   = XW'(HEADER_BYTES);

	state_t        state_q;
	logic [AW-1:0] clr_q;
	logic [7:0]    slack_q;
	logic [15:0]   size_q;
	logic [AW-1:0] p_q;
	logic [XW-1:0] nxt_q;
	logic [AW-1:0] q_q;
	logic          split_q;
	hdr_t          hsave_q;
	logic [AW-1:0] f_q;
	logic [AW-1:0] b_q;
	logic [XW-1:0] nb_q;
	logic [XW-1:0] nn_q;
	logic          mp_q;
	logic          mn_q;
	logic [AW-1:0] keep_q;
	hdr_t          kbase_q;
	logic [SW-1:0] ksize_q;

	// ram ports
	logic          h_we;
	logic [AW-1:0] h_waddr;
	hdr_t          h_wdata;
	logic [AW-1:0] h_raddr;
	logic [HDR_W-1:0] h_rraw;
	hdr_t          h_rd;
	logic          o_we;
	logic [AW-1:0] o_waddr;
	logic          o_wdata;
	logic [AW-1:0] o_raddr;
	logic          o_rd;

	assign h_rd = hdr_t'(h_rraw);

	ffaa_ram #(.WIDTH(HDR_W), .DEPTH(ARENA_BYTES)) u_hdr_ram (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (HDR_W'(h_wdata)),
		.raddr (h_raddr),
		.rdata (h_rraw)
	);

	ffaa_ram #(.WIDTH(1), .DEPTH(ARENA_BYTES)) u_out_ram (
		.clk   (clk),
		.we    (o_we),
		.waddr (o_waddr),
		.wdata (o_wdata),
		.raddr (o_raddr),
		.rdata (o_rd)
	);

	assign busy      = (state_q != S_IDLE);
	// register writes only while no transaction is in progress
	assign cfg_ready = !busy;

	// walk arithmetic on the header just read
	logic [XW-1:0] p_x, s_x, sz_x, nxt_x, q_x, pay_x;
	logic          fit, split;
	assign p_x   = XW'(p_q);
	assign s_x   = XW'(h_rd.size);
	assign sz_x  = XW'(size_q);
	assign nxt_x = p_x + HDR_X + s_x;
	assign pay_x = p_x + HDR_X;
	assign q_x   = pay_x + sz_x;
	assign fit   = h_rd.free && (s_x >= sz_x);
	assign split = (s_x >= sz_x + HDR_X + XW'(slack_q)) && (q_x < ARENA_X);

	// free request front checks
	logic [XW-1:0] f_x;
	assign f_x = XW'(free_offset);

	// free path sums
	logic [XW-1:0] nb_x, ks_prev_x, ks_next_x, nn_x;
	logic          mp, nb_in, mn;
	assign nb_x      = XW'(b_q) + HDR_X + XW'(h_rd.size);
	assign mp        = hsave_q.has_prev && h_rd.free;
	assign ks_prev_x = XW'(h_rd.size) + HDR_X + XW'(hsave_q.size);
	assign nb_in     = nb_q < ARENA_X;
	assign mn        = nb_in && h_rd.free;
	assign ks_next_x = XW'(ksize_q) + HDR_X + XW'(h_rd.size);
	assign nn_x      = nb_q + HDR_X + XW'(h_rd.size);

	// memory port control
	always_comb begin
		h_we    = 1'b0;
		h_waddr = '0;
		h_wdata = h_rd;
		h_raddr = '0;
		o_we    = 1'b0;
		o_waddr = f_q;
		o_wdata = 1'b0;
		o_raddr = free_offset[AW-1:0];
		unique case (state_q)
			S_CLR: begin
				o_we    = 1'b1;
				o_waddr = clr_q;
				h_we    = (clr_q == '0);
				h_wdata = '{size: SW'(ARENA_BYTES - HEADER_BYTES), free: 1'b1,
					prev: '0, has_prev: 1'b0};
			end
			S_IDLE: begin
				h_raddr = (mode == MODE_FREE) ? AW'(f_x - HDR_X) : '0;
			end
			S_ACHK: begin
				h_raddr = nxt_x[AW-1:0];
				if (fit && split) begin
					h_we    = 1'b1;
					h_waddr = q_x[AW-1:0];
					h_wdata = '{size: SW'(s_x - HDR_X - sz_x), free: 1'b1,
						prev: p_q, has_prev: 1'b1};
				end
			end
			S_AFIX: begin
				if (nxt_q < ARENA_X) begin
					h_we    = 1'b1;
					h_waddr = nxt_q[AW-1:0];
					h_wdata = h_rd;
					h_wdata.prev     = q_q;
					h_wdata.has_prev = 1'b1;
				end
			end
			S_AWP: begin
				h_we    = 1'b1;
				h_waddr = p_q;
				h_wdata = hsave_q;
				h_wdata.free = 1'b0;
				if (split_q) begin
					h_wdata.size = SW'(size_q);
				end
				o_we    = (pay_x < ARENA_X);
				o_waddr = pay_x[AW-1:0];
				o_wdata = 1'b1;
			end
			S_FCHK: begin
				h_raddr = h_rd.prev;
				o_we    = o_rd;
				o_waddr = f_q;
			end
			S_FP: begin
				h_raddr = nb_q[AW-1:0];
			end
			S_FN: begin
				h_raddr = nn_x[AW-1:0];
				if (mp_q && nb_in) begin
					h_we    = 1'b1;
					h_waddr = nb_q[AW-1:0];
					h_wdata = h_rd;
					h_wdata.prev     = keep_q;
					h_wdata.has_prev = 1'b1;
				end
			end
			S_FNN: begin
				if (mn_q && nn_q < ARENA_X) begin
					h_we    = 1'b1;
					h_waddr = nn_q[AW-1:0];
					h_wdata = h_rd;
					h_wdata.prev     = keep_q;
					h_wdata.has_prev = 1'b1;
				end
			end
			S_FWK: begin
				h_we    = 1'b1;
				h_waddr = keep_q;
				h_wdata = kbase_q;
				h_wdata.size = ksize_q;
				h_wdata.free = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			slack_q <= SLACK_RESET;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				slack_q <= cfg_data;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(ARENA_BYTES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						if (mode == MODE_ALLOC) begin
							state_q <= S_ACHK;
						end else if (f_x == '0) begin
							done    <= 1'b1;
						end else if (f_x < HDR_X || f_x >= ARENA_X) begin
							done    <= 1'b1;
						end else begin
							state_q <= S_FCHK;
						end
					end
				end
				S_ACHK: begin
					if (fit) begin
						state_q <= split ? S_AFIX : S_AWP;
					end else if (nxt_x + HDR_X > ARENA_X) begin
						done    <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_AFIX: state_q <= S_AWP;
				S_AWP: begin
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				S_FCHK: begin
					if (!o_rd) begin
						done    <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_FP;
					end
				end
				S_FP:  state_q <= S_FN;
				S_FN:  state_q <= S_FNN;
				S_FNN: state_q <= S_FWK;
				S_FWK: begin
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working registers and result
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				size_q <= request_size;
				p_q    <= '0;
				f_q    <= free_offset[AW-1:0];
				b_q    <= AW'(f_x - HDR_X);
				payload_offset <= '0;
				status <= (f_x == '0) ? ST_NULL_FREE : ST_BAD_FREE;
			end
			S_ACHK: begin
				nxt_q   <= nxt_x;
				q_q     <= q_x[AW-1:0];
				split_q <= split;
				hsave_q <= h_rd;
				if (fit) begin
					status <= (size_q == '0) ? ST_ALLOC_ZERO : ST_ALLOC;
					payload_offset <= pay_x[11:0];
				end else begin
					p_q    <= nxt_x[AW-1:0];
					status <= ST_NO_SPACE;
					payload_offset <= '0;
				end
			end
			S_FCHK: begin
				hsave_q <= h_rd;
				nb_q    <= nb_x;
				status  <= o_rd ? ST_FREED : ST_BAD_FREE;
			end
			S_FP: begin
				mp_q <= mp;
				if (mp) begin
					keep_q  <= hsave_q.prev;
					kbase_q <= h_rd;
					ksize_q <= SW'(ks_prev_x);
				end else begin
					keep_q  <= b_q;
					kbase_q <= hsave_q;
					ksize_q <= hsave_q.size;
				end
			end
			S_FN: begin
				mn_q <= mn;
				nn_q <= nn_x;
				if (mn) begin
					ksize_q <= SW'(ks_next_x);
				end
			end
			default: begin
			end
		endcase
	end

	// checks
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status != 3'd6 && status != 3'd7))
		else $error("status code out of range");
	a_no_space_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_NO_SPACE || status == ST_FREED) |-> payload_offset == '0)
		else $error("offset returned without allocation");
	a_start_taken: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !(mode == MODE_FREE && (free_offset == '0 ||
		XW'(free_offset) < HDR_X)) |=> busy)
		else $error("accepted transaction did not start work");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy || $past(state_q == S_IDLE))
		else $error("result strobe while still working");
endmodule
`default_nettype wire
